// ----- rtl/core/ipid_pkg.sv -----
package ipid_pkg;

    // Width of every sample, gain, limit and drive value.
    localparam int DATA_W = 16;

    // Default number of fraction bits in the Q-format gains.
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN   = 3'd5;

    // Reset values of the clamp limits.
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;

    // One input item: speed reference and measured speed.
    typedef struct packed {
        logic signed [DATA_W-1:0] reference;
        logic signed [DATA_W-1:0] feedback;
    } sample_t;

    // One result item: clamped drive and dead-band flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     in_dead_band;
    } result_t;

endpackage

// ----- rtl/core/incremental_pid_deadband_clamp_core.sv -----
// Path: an accepted item goes through the input register, then the result
// register, where it is offered at the result port; a stalled result holds it.
// Throughput: one item per cycle unless the result port stalls; the error, three
// gain products, accumulate and clamp all sit in the single stage between them.
// Reset (rst_n low, asynchronous): gains and dead band go to zero, the clamp to
// the full signed range, stored error, difference and drive to zero.
module incremental_pid_deadband_clamp_core #(
    parameter int GAIN_FRAC_BITS = ipid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipid_pkg::DATA_W-1:0]         cfg_data,
    // Sample channel.
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  ipid_pkg::sample_t                   sample,
    // Result channel.
    output logic                                result_valid,
    input  logic                                result_ready,
    output ipid_pkg::result_t                   result
);

    localparam int W     = ipid_pkg::DATA_W;
    localparam int ERR_W = W + 1;          // reference - feedback
    localparam int DEL_W = W + 2;          // first difference
    localparam int DD_W  = W + 3;          // second difference
    localparam int PRD_W = W + DD_W;       // widest gain product
    localparam int SUM_W = PRD_W + 2;      // sum of three products
    localparam int ACC_W = SUM_W + 1;      // drive plus increment
    localparam logic [SUM_W-1:0] ROUND_MASK =
        (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

    // Configuration registers.
    logic signed [W-1:0] gain_p_reg;
    logic signed [W-1:0] gain_i_reg;
    logic signed [W-1:0] gain_d_reg;
    logic        [W-1:0] dead_band_reg;
    logic signed [W-1:0] out_max_reg;
    logic signed [W-1:0] out_min_reg;

    // Controller state.
    logic signed [ERR_W-1:0] prev_error_reg;
    logic signed [DEL_W-1:0] prev_delta_reg;
    logic signed [W-1:0]     held_drive_reg;

    // Pipeline registers.
    logic                s1_valid_reg;
    ipid_pkg::sample_t   s1_data_reg;
    logic                result_valid_reg;
    ipid_pkg::result_t   result_data_reg;

    logic                    advance;
    logic signed [ERR_W-1:0] err;
    logic signed [DEL_W-1:0] delta;
    logic signed [DD_W-1:0]  delta2;
    logic signed [PRD_W-1:0] prod_p;
    logic signed [PRD_W-1:0] prod_i;
    logic signed [PRD_W-1:0] prod_d;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_adj;
    logic signed [SUM_W-1:0] incr;
    logic signed [ACC_W-1:0] acc;
    logic signed [ERR_W:0]   err_x;
    logic signed [ERR_W:0]   band_pos;
    logic signed [ERR_W:0]   band_neg;
    logic                    in_band;
    logic signed [W-1:0]     drive_next;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            dead_band_reg <= '0;
            out_max_reg   <= ipid_pkg::OUT_MAX_RST;
            out_min_reg   <= ipid_pkg::OUT_MIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ipid_pkg::CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                ipid_pkg::CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                ipid_pkg::CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                ipid_pkg::CFG_DEAD_BAND: dead_band_reg <= cfg_data;
                ipid_pkg::CFG_OUT_MAX:   out_max_reg   <= cfg_data;
                ipid_pkg::CFG_OUT_MIN:   out_min_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // The compute stage moves on when the result register is free or being drained.
    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            s1_data_reg <= sample;
        end
    end

    // Error and its first and second differences.
    always_comb
    begin
        err    = ERR_W'(s1_data_reg.reference) - ERR_W'(s1_data_reg.feedback);
        delta  = DEL_W'(err) - DEL_W'(prev_error_reg);
        delta2 = DD_W'(delta) - DD_W'(prev_delta_reg);
    end

    // Dead band test: inside when -dead_band < err < dead_band.
    always_comb
    begin
        err_x    = (ERR_W + 1)'(err);
        band_pos = $signed({2'b00, dead_band_reg});
        band_neg = -band_pos;
        in_band  = (err_x < band_pos) && (err_x > band_neg);
    end

    // Gain products, their sum, and the shift toward zero by the fraction bits.
    always_comb
    begin
        prod_p  = PRD_W'(gain_p_reg) * PRD_W'(delta);
        prod_i  = PRD_W'(gain_i_reg) * PRD_W'(err);
        prod_d  = PRD_W'(gain_d_reg) * PRD_W'(delta2);
        sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
        sum_adj = sum[SUM_W-1] ? (sum + $signed(ROUND_MASK)) : sum;
        incr    = sum_adj >>> GAIN_FRAC_BITS;
    end

    // Accumulate (no increment inside the dead band) and clamp; the upper limit is checked first.
    always_comb
    begin
        acc = in_band ? ACC_W'(held_drive_reg)
                      : (ACC_W'(held_drive_reg) + ACC_W'(incr));
        if (acc >= ACC_W'(out_max_reg))
        begin
            drive_next = out_max_reg;
        end
        else if (acc <= ACC_W'(out_min_reg))
        begin
            drive_next = out_min_reg;
        end
        else
        begin
            drive_next = acc[W-1:0];
        end
    end

    // State update and result register, both on the item leaving the compute stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg   <= '0;
            prev_delta_reg   <= '0;
            held_drive_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && advance)
            begin
                prev_error_reg <= err;
                prev_delta_reg <= delta;
                held_drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            result_data_reg.drive        <= drive_next;
            result_data_reg.in_dead_band <= in_band;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_data_reg;

    // A pending result always carries the current held drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_data_reg.drive == held_drive_reg))
        else $error("result drive differs from held drive");

    // An item in the compute stage reaches the result register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> result_valid_reg)
        else $error("item lost between compute stage and result register");

    // With both stages full and the result stalled, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid_reg && !result_ready) |-> !sample_ready)
        else $error("sample accepted while the pipeline is full");

endmodule

// ----- tb/pid_drive_checker.sv -----
`timescale 1ns / 100ps

module pid_drive_checker #(
    parameter int GAIN_FRAC_BITS = ipid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipid_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           sample_valid,
    input  logic                           sample_ready,
    input  ipid_pkg::sample_t              sample,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  ipid_pkg::result_t              result,
    output int                             fail_count,
    output int                             pending
);

    // Shadow copy of the configuration registers.
    logic signed [ipid_pkg::DATA_W-1:0] kp;
    logic signed [ipid_pkg::DATA_W-1:0] ki;
    logic signed [ipid_pkg::DATA_W-1:0] kd;
    logic        [ipid_pkg::DATA_W-1:0] band;
    logic signed [ipid_pkg::DATA_W-1:0] hi_limit;
    logic signed [ipid_pkg::DATA_W-1:0] lo_limit;

    // Controller state; error and difference one bit wider than the block's, drive at its width.
    logic signed [17:0]                 prev_err;
    logic signed [18:0]                 prev_diff;
    logic signed [ipid_pkg::DATA_W-1:0] held;

    // Drive values still owed by the block, oldest first.
    ipid_pkg::result_t drive_expect_q[$];

    // Apply one register write to the shadow configuration.
    function automatic void apply_write(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [ipid_pkg::DATA_W-1:0] val);
        case (idx)
            ipid_pkg::CFG_GAIN_P:    kp = val;
            ipid_pkg::CFG_GAIN_I:    ki = val;
            ipid_pkg::CFG_GAIN_D:    kd = val;
            ipid_pkg::CFG_DEAD_BAND: band = val;
            ipid_pkg::CFG_OUT_MAX:   hi_limit = val;
            ipid_pkg::CFG_OUT_MIN:   lo_limit = val;
            default:                 ;
        endcase
    endfunction

    // Advance the controller by one sample and return the clamped drive.
    function automatic ipid_pkg::result_t next_drive(input ipid_pkg::sample_t s);
        longint            err;
        longint            diff;
        longint            diff2;
        longint            acc;
        longint            step;
        longint            lvl;
        logic              quiet;
        ipid_pkg::result_t r;
        err   = longint'(s.reference) - longint'(s.feedback);
        diff  = err - longint'(prev_err);
        diff2 = diff - longint'(prev_diff);
        quiet = (err < longint'(band)) && (err > -longint'(band));
        // The Q-format sum is cut toward zero before it joins the drive.
        acc   = longint'(kp) * diff + longint'(ki) * err + longint'(kd) * diff2;
        step  = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
        lvl   = longint'(held) + (quiet ? 64'sd0 : step);
        // The upper limit wins when the range is inverted.
        if (lvl >= longint'(hi_limit))
            lvl = longint'(hi_limit);
        else if (lvl <= longint'(lo_limit))
            lvl = longint'(lo_limit);
        held      = lvl[ipid_pkg::DATA_W-1:0];
        prev_err  = err[17:0];
        prev_diff = diff[18:0];
        r.drive        = lvl[ipid_pkg::DATA_W-1:0];
        r.in_dead_band = quiet;
        return r;
    endfunction

    // Compare results first, then take in this edge's writes and samples.
    always @(posedge clk or negedge rst_n)
    begin : track
        ipid_pkg::result_t want;
        if (!rst_n)
        begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            band       = '0;
            hi_limit   = ipid_pkg::OUT_MAX_RST;
            lo_limit   = ipid_pkg::OUT_MIN_RST;
            prev_err   = '0;
            prev_diff  = '0;
            held       = '0;
            fail_count = 0;
            drive_expect_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $display("%0t unexpected result item: drive %0d, dead band flag %0b",
                             $time, result.drive, result.in_dead_band);
                    fail_count++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (result.drive !== want.drive)
                    begin
                        $display("%0t drive mismatch: expected %0d, actual %0d",
                                 $time, want.drive, result.drive);
                        fail_count++;
                    end
                    if (result.in_dead_band !== want.in_dead_band)
                    begin
                        $display("%0t dead band flag mismatch: expected %0b, actual %0b",
                                 $time, want.in_dead_band, result.in_dead_band);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
                drive_expect_q.push_back(next_drive(sample));
        end
        pending = drive_expect_q.size();
    end

endmodule

// ----- tb/incremental_pid_deadband_clamp_core_test.sv -----
`timescale 1ns / 100ps

module incremental_pid_deadband_clamp_core_test;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ipid_pkg::DATA_W-1:0]    cfg_data;
    logic                           sample_valid;
    logic                           sample_ready;
    ipid_pkg::sample_t              sample;
    logic                           result_valid;
    logic                           result_ready;
    ipid_pkg::result_t              result;
    int                             fail_count;
    int                             pending;

    // Traffic shaping for the sender and the receiver, and the current dead band.
    int sender_idle_pct;
    int stall_pct;
    bit squeeze_req;
    bit squeeze_done;
    int band_cur;

    incremental_pid_deadband_clamp_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    pid_drive_checker drive_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #200000;
        $display("FAIL incremental_pid_deadband_clamp_core");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back up the pipeline.
    initial
    begin
        int hold;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                for (hold = 0; hold < 300; hold++)
                begin
                    result_ready <= 1'b0;
                    @(posedge clk);
                end
                squeeze_done = 1'b1;
            end
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Write one configuration register; returns at the accepting edge.
    task automatic write_reg(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipid_pkg::DATA_W-1:0] val);
        logic seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            seen = cfg_ready;
            @(posedge clk);
        end
        while (!seen);
    endtask

    // Load a complete controller setting while the block is idle.
    task automatic load_settings(input logic [ipid_pkg::DATA_W-1:0] gp,
                                 input logic [ipid_pkg::DATA_W-1:0] gi,
                                 input logic [ipid_pkg::DATA_W-1:0] gd,
                                 input logic [ipid_pkg::DATA_W-1:0] db,
                                 input logic [ipid_pkg::DATA_W-1:0] hi,
                                 input logic [ipid_pkg::DATA_W-1:0] lo);
        write_reg(ipid_pkg::CFG_GAIN_P, gp);
        write_reg(ipid_pkg::CFG_GAIN_I, gi);
        write_reg(ipid_pkg::CFG_GAIN_D, gd);
        write_reg(ipid_pkg::CFG_DEAD_BAND, db);
        write_reg(ipid_pkg::CFG_OUT_MAX, hi);
        write_reg(ipid_pkg::CFG_OUT_MIN, lo);
        cfg_valid <= 1'b0;
        band_cur = int'(db);
    endtask

    // Offer one sample item, with random idle cycles ahead of it.
    task automatic send_sample(input logic [ipid_pkg::DATA_W-1:0] r,
                               input logic [ipid_pkg::DATA_W-1:0] f);
        logic              seen;
        ipid_pkg::sample_t item;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        item.reference = r;
        item.feedback  = f;
        sample_valid <= 1'b1;
        sample       <= item;
        do
        begin
            @(negedge clk);
            seen = sample_ready;
            @(posedge clk);
        end
        while (!seen);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Stimulus: directed settings first, then random phases.
    initial
    begin
        int                          phase;
        int                          n;
        int                          tgt;
        int                          spread;
        int                          ofs;
        logic [ipid_pkg::DATA_W-1:0] gp;
        logic [ipid_pkg::DATA_W-1:0] gi;
        logic [ipid_pkg::DATA_W-1:0] gd;
        logic [ipid_pkg::DATA_W-1:0] db;
        logic [ipid_pkg::DATA_W-1:0] hi;
        logic [ipid_pkg::DATA_W-1:0] lo;
        logic [ipid_pkg::DATA_W-1:0] r16;
        logic [ipid_pkg::DATA_W-1:0] f16;

        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = ipid_pkg::CFG_GAIN_P;
        cfg_data        = '0;
        sample_valid    = 1'b0;
        sample          = '0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        squeeze_req     = 1'b0;
        squeeze_done    = 1'b0;
        band_cur        = 0;
        tgt             = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero dead band: every item adds an increment; field extremes.
        sender_idle_pct = 33;
        stall_pct       = 33;
        load_settings(16'sd256, 16'sd128, -16'sd64, 16'd0, 16'sh7FFF, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sd100, -16'sd5);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        drain();

        // Dead band edges with extreme gains and a narrow clamp.
        load_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd100, 16'sd1000, -16'sd1000);
        send_sample(16'sd99, 16'sd0);
        send_sample(16'sd100, 16'sd0);
        send_sample(-16'sd99, 16'sd0);
        send_sample(-16'sd100, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd5000, 16'sd0);
        send_sample(-16'sd5000, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000);
        drain();

        // Inverted clamp range and the widest dead band.
        load_settings(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, -16'sd500, 16'sd500);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd10, 16'sd10);
        send_sample(16'sd1000, -16'sd2000);
        drain();

        // Random settings; tracking samples near the set point mostly.
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 61;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 61;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    stall_pct       = 33;
                end
            endcase
            gp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512) - 256);
            gi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(128) - 64);
            gd = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(256) - 128);
            case ($urandom_range(3))
                0:       db = '0;
                1:       db = 16'($urandom_range(64));
                2:       db = 16'($urandom_range(2000));
                default: db = 16'($urandom);
            endcase
            case ($urandom_range(4))
                0:
                begin
                    hi = 16'sh7FFF;
                    lo = 16'sh8000;
                end
                1:
                begin
                    lo = 16'($urandom_range(1000));
                    hi = 16'(-int'($urandom_range(1000)));
                end
                default:
                begin
                    hi = 16'($urandom_range(30000));
                    lo = 16'(-int'($urandom_range(30000)));
                end
            endcase
            load_settings(gp, gi, gd, db, hi, lo);
            if (phase == 0)
                squeeze_req = 1'b1;
            for (n = 0; n < 200; n++)
            begin
                if ($urandom_range(15) == 0)
                    tgt = int'($urandom_range(65535)) - 32768;
                if ($urandom_range(3) == 0)
                begin
                    r16 = 16'($urandom);
                    f16 = 16'($urandom);
                end
                else
                begin
                    spread = band_cur + 8;
                    ofs    = int'($urandom_range(2 * spread)) - spread;
                    r16    = 16'(tgt);
                    f16    = 16'(tgt - ofs);
                    tgt    = tgt + int'($urandom_range(40)) - 20;
                end
                send_sample(r16, f16);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS incremental_pid_deadband_clamp_core");
        else
            $display("FAIL incremental_pid_deadband_clamp_core");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ipid_pkg.sv
rtl/core/incremental_pid_deadband_clamp_core.sv
tb/pid_drive_checker.sv
tb/incremental_pid_deadband_clamp_core_test.sv
